// ===== hw/rtl/min_priority_queue_macros.svh =====
// Assertion macros for the priority queue
`ifndef MIN_PRIORITY_QUEUE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MPQ_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("check failed");
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define MPQ_ASSERT(label, clk, rst, cond)
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/mpq_pkg.sv =====
// Shared types and codes of the priority queue
`timescale 1ns / 1ps
package mpq_pkg;
   localparam int ValueWidth = 32;
   localparam int PrioWidth  = 16;
   localparam int OccWidth   = 5;

   typedef enum logic [1:0] {
      ST_ADDED   = 2'd0,
      ST_REMOVED = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ADD    = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef struct packed {
      logic signed [PrioWidth-1:0]  prio;
      logic signed [ValueWidth-1:0] value;
   } entry_type;
endpackage

// ===== hw/rtl/mpq_ram.sv =====
// Entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module mpq_ram #(
   parameter int Depth = 16,
   parameter int AddrWidth = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AddrWidth-1:0]   wr_addr,
   input  mpq_pkg::entry_type     wr_data,
   input  logic                   rd_en,
   input  logic [AddrWidth-1:0]   rd_addr,
   output mpq_pkg::entry_type     rd_data
);
   mpq_pkg::entry_type mem [Depth];
   mpq_pkg::entry_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/min_priority_queue.sv =====
// Top level of the min-first priority queue
// Usage:
//  req channel: tuser carries the command (add or remove), tdata the pair.
//  rsp channel: one result transaction per request: status, removed pair
//  and the occupancy after the command.
//  Entries sit in one memory as a circular list sorted by priority, ties
//  in arrival order; the head holds the smallest priority.
//  Remove: the head is read from memory, then the result is registered.
//  Add: insertion walks back from the tail, one memory read and one
//  write per cycle, shifting larger entries up. Adding to an empty
//  queue, and the full and empty answers, go straight to S_DONE.
//  A new request is taken once the previous result has been registered.
//  Reset empties the queue at once; memory contents are never cleared.
//  If the receiver stalls, the result holds in the output register and
//  the next command waits at its last step until that register frees.
`timescale 1ns / 1ps
`include "min_priority_queue_macros.svh"
module min_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // element_value[31:0], priority_key[47:32]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // status[1:0], removed_value[33:2],
                                    // removed_priority[49:34], occupancy[54:50]
);
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = IW + 1;
   localparam int OccWidth = mpq_pkg::OccWidth;

   typedef enum logic [2:0] {
      S_IDLE, S_ADD_CMP, S_ADD_PUT, S_REM_RD, S_DONE
   } state_type;

   state_type              state_ff;
   logic [IW-1:0]          head_ff, cur_ff;
   logic [CW-1:0]          count_ff, left_ff;
   mpq_pkg::entry_type     new_ff;
   mpq_pkg::status_type    res_status_ff;
   mpq_pkg::entry_type     res_entry_ff;
   logic                   rsp_valid_ff;
   mpq_pkg::status_type    rsp_status_ff;
   mpq_pkg::entry_type     rsp_entry_ff;
   logic [CW-1:0]          rsp_count_ff;

   logic                   wr_en, rd_en;
   logic [IW-1:0]          wr_addr, rd_addr;
   mpq_pkg::entry_type     wr_data, rd_data;
   logic [SW-1:0]          tail_sum;
   logic [IW-1:0]          tail_idx, cur_dec, cur_dec2;
   logic                   req_fire, shift_up, out_free;

   function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] x);
      dec_idx = (x == '0) ? IW'(CAPACITY - 1) : x - 1'b1;
   endfunction

   function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
      inc_idx = (x == IW'(CAPACITY - 1)) ? '0 : x + 1'b1;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // physical slot past the last entry
   assign tail_sum = {1'b0, head_ff} + SW'(count_ff);
   assign tail_idx = (tail_sum >= SW'(CAPACITY)) ? IW'(tail_sum - SW'(CAPACITY))
                                                 : IW'(tail_sum);
   assign cur_dec  = dec_idx(cur_ff);
   assign cur_dec2 = dec_idx(cur_dec);
   assign shift_up = (rd_data.prio > new_ff.prio);

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = new_ff;
      rd_en   = 1'b0;
      rd_addr = head_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser == mpq_pkg::CMD_ADD && count_ff != '0 &&
                count_ff != CW'(CAPACITY)) begin
               rd_en   = 1'b1;
               rd_addr = dec_idx(tail_idx);
            end else if (req_fire && req_tuser == mpq_pkg::CMD_ADD &&
                         count_ff == '0) begin
               wr_en   = 1'b1;
               wr_addr = head_ff;
               wr_data = {req_tdata[47:32], req_tdata[31:0]};
            end else if (req_fire && req_tuser == mpq_pkg::CMD_REMOVE &&
                         count_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = head_ff;
            end
         end
         S_ADD_CMP: begin
            wr_en = 1'b1;
            if (shift_up) begin
               wr_data = rd_data;
               rd_en   = (left_ff != CW'(1));
               rd_addr = cur_dec2;
            end
         end
         S_ADD_PUT: wr_en = 1'b1;
         default: ;
      endcase
   end

   mpq_ram #(.Depth(CAPACITY), .AddrWidth(IW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  new_ff       <= {req_tdata[47:32], req_tdata[31:0]};
                  res_entry_ff <= '0;
                  cur_ff       <= tail_idx;
                  left_ff      <= count_ff;
                  state_ff     <= S_DONE;
                  if (req_tuser == mpq_pkg::CMD_ADD) begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_status_ff <= mpq_pkg::ST_FULL;
                     end else begin
                        res_status_ff <= mpq_pkg::ST_ADDED;
                        if (count_ff == '0) begin
                           count_ff <= CW'(1);
                        end else begin
                           state_ff <= S_ADD_CMP;
                        end
                     end
                  end else if (count_ff == '0) begin
                     res_status_ff <= mpq_pkg::ST_EMPTY;
                  end else begin
                     res_status_ff <= mpq_pkg::ST_REMOVED;
                     state_ff      <= S_REM_RD;
                  end
               end
            end
            S_ADD_CMP: begin
               if (shift_up) begin
                  cur_ff  <= cur_dec;
                  left_ff <= left_ff - 1'b1;
                  if (left_ff == CW'(1)) begin
                     state_ff <= S_ADD_PUT;
                  end
               end else begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_DONE;
               end
            end
            S_ADD_PUT: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_DONE;
            end
            S_REM_RD: begin
               res_entry_ff <= rd_data;
               head_ff      <= inc_idx(head_ff);
               count_ff     <= count_ff - 1'b1;
               state_ff     <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_entry_ff  <= res_entry_ff;
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, OccWidth'(rsp_count_ff), rsp_entry_ff.prio,
                        rsp_entry_ff.value, rsp_status_ff};

   `MPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY))
   `MPQ_ASSERT_NEXT(a_empty_fast, clock, reset,
      req_fire && req_tuser == mpq_pkg::CMD_REMOVE && count_ff == '0,
      state_ff == S_DONE && res_status_ff == mpq_pkg::ST_EMPTY)
   `MPQ_ASSERT_NEXT(a_remove_dec, clock, reset,
      state_ff == S_REM_RD, count_ff == $past(count_ff) - 1'b1)
endmodule
